// ----- hdl/swat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swat_pkg
// Shared widths, limits and event codes of the sender ack window tracker.
// ----------------------------------------------------------------------------
package swat_pkg;

  // field widths
  localparam int SEQ_W = 31;
  localparam int WIN_W = 13;
  localparam int REL_W = 13;
  localparam int KIND_W = 2;

  // window limits
  localparam logic [WIN_W-1:0] MAX_WINDOW = WIN_W'(4096);
  localparam logic [WIN_W-1:0] MIN_WINDOW = WIN_W'(1);
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);
  localparam logic [WIN_W-1:0] THRESH_RESET = WIN_W'(16);
  localparam logic [REL_W-1:0] REL_MAX = REL_W'(8191);

  // event codes of a result
  localparam logic [KIND_W-1:0] EV_IN_ORDER = 2'd0;
  localparam logic [KIND_W-1:0] EV_OUT_OF_ORDER = 2'd1;
  localparam logic [KIND_W-1:0] EV_OLD = 2'd2;
  localparam logic [KIND_W-1:0] EV_TIMEOUT = 2'd3;

  // configuration register indexes
  localparam logic CFG_GROWTH = 1'b0;
  localparam logic CFG_DECLINE = 1'b1;

endpackage

// ----- hdl/sender_ack_window_tracker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sender_ack_window_tracker_top
// Sender-side ack tracker with AIMD congestion window and selective marks.
// ----------------------------------------------------------------------------
// After reset the block sweeps the mark memory clear, one entry a cycle, so
// in_ready stays low until the sweep is done (configuration writes are taken
// at any time). One item at a time is processed: a timeout or an old ack goes
// straight to the result stage, an out-of-order ack waits for the modulo unit
// (it needs three steps of reciprocal multiplication and correction before
// the mark is set), and an in-order ack walks past the marked slots after it,
// each walk step being a read and a check through the registered RAM read
// port. Results sit in an output register, so the next item may be taken
// while a result waits.
// ----------------------------------------------------------------------------
module sender_ack_window_tracker_top
  import swat_pkg::*;
#(
  parameter int WINDOW = 4096
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [WIN_W-1:0]  cfg_data,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [SEQ_W-1:0]  ack_number,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WIN_W-1:0]  window_size,
  output logic [SEQ_W-1:0]  next_expected,
  output logic [REL_W-1:0]  slots_released,
  output logic [KIND_W-1:0] event_kind
);

  localparam int SW = $clog2(WINDOW);
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);
  localparam logic [SW:0] WALK_LIMIT = (SW + 1)'(WINDOW);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_WALK_RD  = 3'd2;
  localparam logic [2:0] S_WALK_CHK = 3'd3;
  localparam logic [2:0] S_MOD      = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;

  logic [2:0]        state;
  logic [WIN_W-1:0]  growth_threshold;
  logic [WIN_W-1:0]  decline_threshold;
  logic [WIN_W-1:0]  window_register;
  logic [SEQ_W-1:0]  expected_ack;
  logic [WIN_W-1:0]  growth_count;
  logic [SW-1:0]     exp_slot;
  logic [SW-1:0]     walk_slot;
  logic [SW:0]       walk_steps;
  logic [SW-1:0]     clr_addr;
  logic [REL_W-1:0]  released;
  logic [KIND_W-1:0] kind;

  logic [WIN_W-1:0]  win_grow;
  logic [WIN_W-1:0]  cnt_grow;
  logic [WIN_W-1:0]  win_shrink;
  logic [SW-1:0]     exp_slot_inc;
  logic [SW-1:0]     exp_slot_adv;
  logic [SW-1:0]     walk_slot_inc;

  logic              ram_we;
  logic [SW-1:0]     ram_waddr;
  logic              ram_wdata;
  logic              ram_rdata;

  logic              mod_start;
  logic              mod_done;
  logic [SW-1:0]     mod_rem;

  logic              in_xfer;
  logic              walk_go;
  logic              emit_go;

  // slot increments with wrap at the window depth
  assign exp_slot_inc  = (exp_slot == LAST_SLOT) ? '0 : exp_slot + SW'(1);
  assign walk_slot_inc = (walk_slot == LAST_SLOT) ? '0 : walk_slot + SW'(1);

  // expected slot restarts at zero when the sequence number wraps
  assign exp_slot_adv  = (expected_ack == '1) ? '0 : exp_slot_inc;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign walk_go  = (walk_steps < WALK_LIMIT) && ram_rdata;
  assign mod_start = in_xfer && !req_type && (ack_number > expected_ack);
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  // additive growth of the window
  always_comb begin
    logic [WIN_W:0] wsum;
    logic [WIN_W:0] csum;
    wsum = {1'b0, window_register} + (WIN_W + 1)'(1);
    csum = {1'b0, growth_count} + (WIN_W + 1)'(1);
    cnt_grow = growth_count;
    if (window_register < growth_threshold) begin
      win_grow = (wsum > {1'b0, MAX_WINDOW}) ? MAX_WINDOW : wsum[WIN_W-1:0];
    end else if (csum >= {1'b0, window_register}) begin
      win_grow = (wsum > {1'b0, MAX_WINDOW}) ? MAX_WINDOW : wsum[WIN_W-1:0];
      cnt_grow = '0;
    end else begin
      win_grow = window_register;
      cnt_grow = csum[WIN_W-1:0];
    end
  end

  // multiplicative decrease above the decline threshold, else minus one, with a floor
  always_comb begin
    logic [WIN_W-1:0] w;
    if (window_register > decline_threshold) begin
      w = window_register >> 1;
    end else if (window_register != '0) begin
      w = window_register - WIN_W'(1);
    end else begin
      w = window_register;
    end
    win_shrink = (w < MIN_WINDOW) ? MIN_WINDOW : w;
  end

  // mark memory write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = exp_slot;
    ram_wdata = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_IDLE: begin
        ram_we = in_xfer && !req_type && (ack_number == expected_ack);
      end
      S_WALK_CHK: begin
        ram_we    = walk_go;
        ram_waddr = walk_slot;
      end
      S_MOD: begin
        ram_we    = mod_done;
        ram_waddr = mod_rem;
        ram_wdata = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  swat_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_slot),
    .rdata (ram_rdata)
  );

  swat_mod #(
    .WINDOW (WINDOW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (ack_number),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      growth_threshold  <= THRESH_RESET;
      decline_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GROWTH:  growth_threshold  <= cfg_data;
        CFG_DECLINE: decline_threshold <= cfg_data;
        default:     growth_threshold  <= growth_threshold;
      endcase
    end
  end

  // control sequencer and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      window_register <= WINDOW_RESET;
      expected_ack    <= '0;
      growth_count    <= '0;
      exp_slot        <= '0;
      walk_slot       <= '0;
      walk_steps      <= '0;
      released        <= '0;
      kind            <= EV_IN_ORDER;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SW'(1);
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            released <= '0;
            if (req_type) begin
              window_register <= win_shrink;
              kind            <= EV_TIMEOUT;
              state           <= S_EMIT;
            end else if (ack_number == expected_ack) begin
              window_register <= win_grow;
              growth_count    <= cnt_grow;
              expected_ack    <= expected_ack + SEQ_W'(1);
              exp_slot        <= exp_slot_adv;
              walk_slot       <= exp_slot_inc;
              walk_steps      <= '0;
              released        <= REL_W'(1);
              kind            <= EV_IN_ORDER;
              state           <= S_WALK_RD;
            end else if (ack_number > expected_ack) begin
              kind  <= EV_OUT_OF_ORDER;
              state <= S_MOD;
            end else begin
              kind  <= EV_OLD;
              state <= S_EMIT;
            end
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (walk_go) begin
            expected_ack <= expected_ack + SEQ_W'(1);
            exp_slot     <= exp_slot_adv;
            walk_slot    <= walk_slot_inc;
            walk_steps   <= walk_steps + (SW + 1)'(1);
            if (released != REL_MAX) begin
              released <= released + REL_W'(1);
            end
            state <= S_WALK_RD;
          end else begin
            state <= S_EMIT;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            window_register <= win_grow;
            growth_count    <= cnt_grow;
            state           <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      window_size    <= window_register;
      next_expected  <= expected_ack;
      slots_released <= released;
      event_kind     <= kind;
    end
  end

endmodule

// ----- hdl/swat_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/swat_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swat_mod
// Sequence number modulo window size by reciprocal multiplication, one
// multiply, one back-multiply and one subtract-and-correct step in turn.
// ----------------------------------------------------------------------------
module swat_mod
  import swat_pkg::*;
#(
  parameter int WINDOW = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [SEQ_W-1:0]          value,
  output logic                      done,
  output logic [$clog2(WINDOW)-1:0] rem
);

  localparam int SW = $clog2(WINDOW);
  localparam int SHIFT = SEQ_W + SW;
  localparam int RCP_W = SEQ_W + 1;
  localparam int PROD_W = SEQ_W + RCP_W;
  localparam logic [63:0] RCP_FULL = (64'd1 << SHIFT) / 64'(WINDOW);
  localparam logic [RCP_W-1:0] RECIP = RCP_FULL[RCP_W-1:0];
  localparam logic [SEQ_W-1:0] DIVISOR = SEQ_W'(WINDOW);
  localparam logic [SW:0] MODULUS = (SW + 1)'(WINDOW);

  logic              stage1;
  logic              stage2;
  logic              stage3;
  logic [SEQ_W-1:0]  val;
  logic [PROD_W-1:0] prod;
  logic [SEQ_W-1:0]  quot;
  logic [SEQ_W-1:0]  qmul;
  logic [SEQ_W-1:0]  diff;
  logic [SW:0]       part;
  logic [SW:0]       part_red;

  // quotient estimate is exact or one short, so one correction suffices
  assign quot     = SEQ_W'(prod >> SHIFT);
  assign diff     = val - qmul;
  assign part     = diff[SW:0];
  assign part_red = part - MODULUS;

  // step tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      stage3 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      stage3 <= stage2;
      done   <= stage3;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      val <= value;
    end
    prod <= PROD_W'(val) * PROD_W'(RECIP);
    qmul <= quot * DIVISOR;
    rem  <= (part >= MODULUS) ? part_red[SW-1:0] : part[SW-1:0];
  end

endmodule
